// ===== src/nvrp_pkg.sv =====
`default_nettype none

package nvrp_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned DELTA_W = 18;
    localparam int unsigned DOT_W   = 36;
    localparam int unsigned PEXT_W  = 53;
    localparam int unsigned PERP_W  = 25;
    localparam int unsigned SQSUM_W = 51;
    localparam int unsigned DIST_W  = 32;
    localparam int unsigned OBJ_W   = 8;
    localparam int unsigned VTX_W   = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned ROUND_SHIFT = 28;

    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAY_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAY_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RAY_Z     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd6;

    localparam logic signed [COORD_W-1:0] RAY_Z_RESET     = 16'sd16384;
    localparam logic [DIST_W-1:0]         THRESHOLD_RESET = 32'd5898;
    localparam logic [DIST_W-1:0]         DIST_MAX        = '1;

    typedef logic [1:0] axis_t;
    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DOT,
        ST_PERP,
        ST_SQ,
        ST_CMP
    } nvrp_state_t;

    typedef struct packed {
        logic  load;
        logic  dot;
        logic  perp;
        logic  sq;
        logic  cmp;
        axis_t axis;
    } nvrp_cmd_t;

    typedef struct packed {
        logic last;
        logic out_blocked;
    } nvrp_stat_t;

endpackage

`default_nettype wire

// ===== src/nvrp_ctrl.sv =====
`default_nettype none

module nvrp_ctrl
    import nvrp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire nvrp_stat_t  stat,
    output nvrp_cmd_t        cmd,
    output nvrp_state_t      state
);

    nvrp_state_t state_reg;
    nvrp_state_t state_next;
    axis_t       axis_reg;
    axis_t       axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= AXIS_X;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DOT;
                    axis_next  = AXIS_X;
                end
            end
            ST_DOT:
            begin
                if (axis_reg == AXIS_Z)
                begin
                    state_next = ST_PERP;
                    axis_next  = AXIS_X;
                end
                else
                begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            ST_PERP:
            begin
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                if (axis_reg == AXIS_Z)
                begin
                    state_next = ST_CMP;
                    axis_next  = AXIS_X;
                end
                else
                begin
                    state_next = ST_PERP;
                    axis_next  = axis_reg + 2'd1;
                end
            end
            ST_CMP:
            begin
                if (!(stat.last && stat.out_blocked))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                axis_next  = AXIS_X;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        cmd.axis = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DOT:
            begin
                cmd.dot = 1'b1;
            end
            ST_PERP:
            begin
                cmd.perp = 1'b1;
            end
            ST_SQ:
            begin
                cmd.sq = 1'b1;
            end
            ST_CMP:
            begin
                cmd.cmp = !(stat.last && stat.out_blocked);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign state = state_reg;

endmodule

`default_nettype wire

// ===== src/nvrp_datapath.sv =====
`default_nettype none

module nvrp_datapath
    import nvrp_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_data,
    input  wire logic signed [COORD_W-1:0]    object_x,
    input  wire logic signed [COORD_W-1:0]    object_y,
    input  wire logic signed [COORD_W-1:0]    object_z,
    input  wire logic signed [COORD_W-1:0]    vertex_x,
    input  wire logic signed [COORD_W-1:0]    vertex_y,
    input  wire logic signed [COORD_W-1:0]    vertex_z,
    input  wire logic [OBJ_W-1:0]             object_index,
    input  wire logic [VTX_W-1:0]             vertex_index,
    input  wire logic                         frame_last,
    input  wire nvrp_cmd_t                    cmd,
    output nvrp_stat_t                        stat,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              hovered,
    output logic [OBJ_W-1:0]                  best_object,
    output logic [VTX_W-1:0]                  best_vertex,
    output logic [DIST_W-1:0]                 min_distance_sq
);

    logic signed [COORD_W-1:0] camera_x_reg;
    logic signed [COORD_W-1:0] camera_y_reg;
    logic signed [COORD_W-1:0] camera_z_reg;
    logic signed [COORD_W-1:0] ray_x_reg;
    logic signed [COORD_W-1:0] ray_y_reg;
    logic signed [COORD_W-1:0] ray_z_reg;
    logic [DIST_W-1:0]         threshold_reg;

    logic signed [DELTA_W-1:0] d_reg [3];
    logic signed [PERP_W-1:0]  p_reg [3];
    logic signed [DOT_W-1:0]   acc_reg;
    logic [SQSUM_W-1:0]        sq_reg;
    logic [OBJ_W-1:0]          obj_reg;
    logic [VTX_W-1:0]          vtx_reg;
    logic                      last_reg;

    logic [DIST_W-1:0]         min_reg;
    logic [OBJ_W-1:0]          best_obj_reg;
    logic [VTX_W-1:0]          best_vtx_reg;

    logic                      out_valid_reg;
    logic                      hovered_reg;
    logic [OBJ_W-1:0]          out_obj_reg;
    logic [VTX_W-1:0]          out_vtx_reg;
    logic [DIST_W-1:0]         out_dist_reg;

    logic signed [DELTA_W-1:0] dx_in;
    logic signed [DELTA_W-1:0] dy_in;
    logic signed [DELTA_W-1:0] dz_in;
    logic signed [COORD_W-1:0] ray_sel;
    logic signed [DELTA_W-1:0] d_sel;
    logic signed [DELTA_W+COORD_W-1:0] dot_prod;
    logic signed [DOT_W+COORD_W-1:0]   perp_prod;
    logic signed [PEXT_W-1:0]  perp_ext;
    logic signed [PERP_W-1:0]  perp_q8;
    logic signed [2*PERP_W-1:0] sq_prod;
    logic [DIST_W-1:0]         dist_sat;
    logic                      better;
    logic [DIST_W-1:0]         min_upd;
    logic [OBJ_W-1:0]          obj_upd;
    logic [VTX_W-1:0]          vtx_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            camera_x_reg  <= '0;
            camera_y_reg  <= '0;
            camera_z_reg  <= '0;
            ray_x_reg     <= '0;
            ray_y_reg     <= '0;
            ray_z_reg     <= RAY_Z_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_CAMERA_X:  camera_x_reg  <= cfg_data[COORD_W-1:0];
                CFG_CAMERA_Y:  camera_y_reg  <= cfg_data[COORD_W-1:0];
                CFG_CAMERA_Z:  camera_z_reg  <= cfg_data[COORD_W-1:0];
                CFG_RAY_X:     ray_x_reg     <= cfg_data[COORD_W-1:0];
                CFG_RAY_Y:     ray_y_reg     <= cfg_data[COORD_W-1:0];
                CFG_RAY_Z:     ray_z_reg     <= cfg_data[COORD_W-1:0];
                CFG_THRESHOLD: threshold_reg <= cfg_data[DIST_W-1:0];
                default:       threshold_reg <= threshold_reg;
            endcase
        end
    end

    // world position minus camera
    assign dx_in = {{2{object_x[COORD_W-1]}}, object_x} + {{2{vertex_x[COORD_W-1]}}, vertex_x}
                 - {{2{camera_x_reg[COORD_W-1]}}, camera_x_reg};
    assign dy_in = {{2{object_y[COORD_W-1]}}, object_y} + {{2{vertex_y[COORD_W-1]}}, vertex_y}
                 - {{2{camera_y_reg[COORD_W-1]}}, camera_y_reg};
    assign dz_in = {{2{object_z[COORD_W-1]}}, object_z} + {{2{vertex_z[COORD_W-1]}}, vertex_z}
                 - {{2{camera_z_reg[COORD_W-1]}}, camera_z_reg};

    always_comb
    begin
        case (cmd.axis)
            AXIS_X:  ray_sel = ray_x_reg;
            AXIS_Y:  ray_sel = ray_y_reg;
            AXIS_Z:  ray_sel = ray_z_reg;
            default: ray_sel = ray_z_reg;
        endcase
    end

    assign d_sel     = d_reg[cmd.axis];
    assign dot_prod  = ray_sel * d_sel;
    assign perp_prod = acc_reg * ray_sel;

    // exact perpendicular component, then round half up to q8.8
    assign perp_ext = PEXT_W'(perp_prod)
                    - (PEXT_W'(d_sel) <<< ROUND_SHIFT)
                    + (PEXT_W'(1) <<< (ROUND_SHIFT - 1));
    assign perp_q8  = perp_ext[PEXT_W-1:ROUND_SHIFT];

    assign sq_prod  = p_reg[cmd.axis] * p_reg[cmd.axis];

    assign dist_sat = (|sq_reg[SQSUM_W-1:DIST_W]) ? DIST_MAX : sq_reg[DIST_W-1:0];
    assign better   = dist_sat < min_reg;
    assign min_upd  = better ? dist_sat : min_reg;
    assign obj_upd  = better ? obj_reg : best_obj_reg;
    assign vtx_upd  = better ? vtx_reg : best_vtx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            d_reg[0] <= dx_in;
            d_reg[1] <= dy_in;
            d_reg[2] <= dz_in;
            obj_reg  <= object_index;
            vtx_reg  <= vertex_index;
            last_reg <= frame_last;
            acc_reg  <= '0;
            sq_reg   <= '0;
        end
        if (cmd.dot)
        begin
            acc_reg <= acc_reg + DOT_W'(dot_prod);
        end
        if (cmd.perp)
        begin
            p_reg[cmd.axis] <= perp_q8;
        end
        if (cmd.sq)
        begin
            sq_reg <= sq_reg + {2'b00, sq_prod[2*PERP_W-2:0]};
        end
    end

    // running minimum, cleared after each frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg      <= DIST_MAX;
            best_obj_reg <= '0;
            best_vtx_reg <= '0;
        end
        else if (cmd.cmp)
        begin
            if (last_reg)
            begin
                min_reg      <= DIST_MAX;
                best_obj_reg <= '0;
                best_vtx_reg <= '0;
            end
            else
            begin
                min_reg      <= min_upd;
                best_obj_reg <= obj_upd;
                best_vtx_reg <= vtx_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.cmp && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cmp && last_reg)
        begin
            hovered_reg  <= (min_upd <= threshold_reg);
            out_obj_reg  <= obj_upd;
            out_vtx_reg  <= vtx_upd;
            out_dist_reg <= min_upd;
        end
    end

    assign stat.last        = last_reg;
    assign stat.out_blocked = out_valid_reg && !out_ready;

    assign out_valid       = out_valid_reg;
    assign hovered         = hovered_reg;
    assign best_object     = out_obj_reg;
    assign best_vertex     = out_vtx_reg;
    assign min_distance_sq = out_dist_reg;

endmodule

`default_nettype wire

// ===== src/nearest_vertex_to_ray_pick_core.sv =====
// channel   direction   handshake              payload
// config    in          cfg_write              cfg_index, cfg_data
// vertex    in          in_valid / in_ready    object_*, vertex_*, indices, frame_last
// result    out         out_valid / out_ready  hovered, best_object, best_vertex, min_distance_sq
//
// each vertex goes through: one step to take it, three dot product steps, three
// perpendicular and square step pairs on the shared multipliers, one compare, before the next is taken
// reset clears the running minimum and out_valid and loads the config defaults
// a waiting result stalls only the compare of the next frame's last vertex
`default_nettype none

module nearest_vertex_to_ray_pick_core
    import nvrp_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [COORD_W-1:0]  object_x,
    input  wire logic signed [COORD_W-1:0]  object_y,
    input  wire logic signed [COORD_W-1:0]  object_z,
    input  wire logic signed [COORD_W-1:0]  vertex_x,
    input  wire logic signed [COORD_W-1:0]  vertex_y,
    input  wire logic signed [COORD_W-1:0]  vertex_z,
    input  wire logic [OBJ_W-1:0]           object_index,
    input  wire logic [VTX_W-1:0]           vertex_index,
    input  wire logic                       frame_last,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            hovered,
    output logic [OBJ_W-1:0]                best_object,
    output logic [VTX_W-1:0]                best_vertex,
    output logic [DIST_W-1:0]               min_distance_sq
);

    nvrp_cmd_t   cmd;
    nvrp_stat_t  stat;
    nvrp_state_t state;

    nvrp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd),
        .state    (state)
    );

    nvrp_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .object_x        (object_x),
        .object_y        (object_y),
        .object_z        (object_z),
        .vertex_x        (vertex_x),
        .vertex_y        (vertex_y),
        .vertex_z        (vertex_z),
        .object_index    (object_index),
        .vertex_index    (vertex_index),
        .frame_last      (frame_last),
        .cmd             (cmd),
        .stat            (stat),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .hovered         (hovered),
        .best_object     (best_object),
        .best_vertex     (best_vertex),
        .min_distance_sq (min_distance_sq)
    );

    a_busy_after_transfer: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("input taken while previous vertex in flight");

    a_result_from_compare: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state == ST_CMP)
    ) else $error("result appeared outside compare step");

    a_saturated_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && min_distance_sq == DIST_MAX) |-> (best_object == '0 && best_vertex == '0)
    ) else $error("saturated minimum carries nonzero indices");

    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !(cmd.cmp && stat.last)
    ) else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== tb/sv/nearest_pick_checker.sv =====
`timescale 1ns / 100ps

module nearest_pick_checker
    import nvrp_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                       in_valid,
    input  wire logic                       in_ready,
    input  wire logic signed [COORD_W-1:0]  object_x,
    input  wire logic signed [COORD_W-1:0]  object_y,
    input  wire logic signed [COORD_W-1:0]  object_z,
    input  wire logic signed [COORD_W-1:0]  vertex_x,
    input  wire logic signed [COORD_W-1:0]  vertex_y,
    input  wire logic signed [COORD_W-1:0]  vertex_z,
    input  wire logic [OBJ_W-1:0]           object_index,
    input  wire logic [VTX_W-1:0]           vertex_index,
    input  wire logic                       frame_last,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire logic                       hovered,
    input  wire logic [OBJ_W-1:0]           best_object,
    input  wire logic [VTX_W-1:0]           best_vertex,
    input  wire logic [DIST_W-1:0]          min_distance_sq,
    output int                              mismatch_count,
    output int                              pending_results
);

    typedef struct packed {
        logic              hov;
        logic [OBJ_W-1:0]  obj;
        logic [VTX_W-1:0]  vtx;
        logic [DIST_W-1:0] dist_sq;
    } pick_t;

    pick_t nearest_picks[$];

    logic signed [COORD_W-1:0] cam_x, cam_y, cam_z;
    logic signed [COORD_W-1:0] dir_x, dir_y, dir_z;
    logic [DIST_W-1:0]         hover_limit;

    logic [DIST_W-1:0] frame_min_sq;
    logic [OBJ_W-1:0]  frame_best_obj;
    logic [VTX_W-1:0]  frame_best_vtx;

    // perpendicular component, exact product rounded half up back to Q8.8
    function automatic longint perp_q8(longint dot, longint dir, longint delta);
        longint exact;
        exact = dot * dir - delta * 64'sd268435456;
        return (exact + 64'sd134217728) >>> ROUND_SHIFT;
    endfunction

    function automatic logic [DIST_W-1:0] ray_distance_sq(longint dx, longint dy, longint dz);
        longint dot;
        longint px;
        longint py;
        longint pz;
        longint sum;
        dot = longint'(dir_x) * dx + longint'(dir_y) * dy + longint'(dir_z) * dz;
        px  = perp_q8(dot, longint'(dir_x), dx);
        py  = perp_q8(dot, longint'(dir_y), dy);
        pz  = perp_q8(dot, longint'(dir_z), dz);
        sum = px * px + py * py + pz * pz;
        return (sum > 64'sd4294967295) ? DIST_MAX : DIST_W'(sum);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : pick_model
        logic [DIST_W-1:0] vertex_dist;
        pick_t             want;
        pick_t             got;
        if (!rst_n)
        begin
            cam_x          = '0;
            cam_y          = '0;
            cam_z          = '0;
            dir_x          = '0;
            dir_y          = '0;
            dir_z          = RAY_Z_RESET;
            hover_limit    = THRESHOLD_RESET;
            frame_min_sq   = DIST_MAX;
            frame_best_obj = '0;
            frame_best_vtx = '0;
            mismatch_count = 0;
            nearest_picks.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_CAMERA_X:  cam_x = cfg_data[COORD_W-1:0];
                    CFG_CAMERA_Y:  cam_y = cfg_data[COORD_W-1:0];
                    CFG_CAMERA_Z:  cam_z = cfg_data[COORD_W-1:0];
                    CFG_RAY_X:     dir_x = cfg_data[COORD_W-1:0];
                    CFG_RAY_Y:     dir_y = cfg_data[COORD_W-1:0];
                    CFG_RAY_Z:     dir_z = cfg_data[COORD_W-1:0];
                    CFG_THRESHOLD: hover_limit = cfg_data[DIST_W-1:0];
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                got = '{hovered, best_object, best_vertex, min_distance_sq};
                if (nearest_picks.size() == 0)
                begin
                    $error("result transfer with no frame pending: best_object %0d best_vertex %0d",
                           best_object, best_vertex);
                    mismatch_count++;
                end
                else
                begin
                    want = nearest_picks.pop_front();
                    if (got.hov !== want.hov)
                    begin
                        $error("hovered expected %0d actual %0d", want.hov, got.hov);
                        mismatch_count++;
                    end
                    if (got.obj !== want.obj)
                    begin
                        $error("best_object expected %0d actual %0d", want.obj, got.obj);
                        mismatch_count++;
                    end
                    if (got.vtx !== want.vtx)
                    begin
                        $error("best_vertex expected %0d actual %0d", want.vtx, got.vtx);
                        mismatch_count++;
                    end
                    if (got.dist_sq !== want.dist_sq)
                    begin
                        $error("min_distance_sq expected %0h actual %0h",
                               want.dist_sq, got.dist_sq);
                        mismatch_count++;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                vertex_dist = ray_distance_sq(
                    longint'(object_x) + longint'(vertex_x) - longint'(cam_x),
                    longint'(object_y) + longint'(vertex_y) - longint'(cam_y),
                    longint'(object_z) + longint'(vertex_z) - longint'(cam_z));
                // strict compare: first of equal distances keeps the pick
                if (vertex_dist < frame_min_sq)
                begin
                    frame_min_sq   = vertex_dist;
                    frame_best_obj = object_index;
                    frame_best_vtx = vertex_index;
                end
                if (frame_last)
                begin
                    nearest_picks.push_back('{frame_min_sq <= hover_limit, frame_best_obj,
                                              frame_best_vtx, frame_min_sq});
                    frame_min_sq   = DIST_MAX;
                    frame_best_obj = '0;
                    frame_best_vtx = '0;
                end
            end
        end
        pending_results = nearest_picks.size();
    end

endmodule

// ===== tb/sv/nearest_vertex_to_ray_pick_core_tb.sv =====
`timescale 1ns / 100ps

module nearest_vertex_to_ray_pick_core_tb;
    import nvrp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SEGMENTS      = 12;
    localparam int SEGMENT_ITEMS = 96;
    localparam int DRAIN_CYCLES  = 30;

    typedef struct packed {
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic signed [COORD_W-1:0] oz;
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic signed [COORD_W-1:0] vz;
        logic [OBJ_W-1:0]          obj;
        logic [VTX_W-1:0]          vtx;
        logic                      last;
    } vertex_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [COORD_W-1:0]  object_x = '0;
    logic signed [COORD_W-1:0]  object_y = '0;
    logic signed [COORD_W-1:0]  object_z = '0;
    logic signed [COORD_W-1:0]  vertex_x = '0;
    logic signed [COORD_W-1:0]  vertex_y = '0;
    logic signed [COORD_W-1:0]  vertex_z = '0;
    logic [OBJ_W-1:0]           object_index = '0;
    logic [VTX_W-1:0]           vertex_index = '0;
    logic                       frame_last = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       hovered;
    logic [OBJ_W-1:0]           best_object;
    logic [VTX_W-1:0]           best_vertex;
    logic [DIST_W-1:0]          min_distance_sq;
    int                         mismatch_count;
    int                         pending_results;

    int          send_idle_pct = 20;
    int          recv_idle_pct = 88;
    int unsigned cycle_count = 0;

    nearest_vertex_to_ray_pick_core u_dut (.*);

    nearest_pick_checker u_checker (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic vertex_t mk(int ox, int oy, int oz, int vx, int vy, int vz,
                                   int obj, int vtx, bit last);
        vertex_t v;
        v.ox   = COORD_W'(ox);
        v.oy   = COORD_W'(oy);
        v.oz   = COORD_W'(oz);
        v.vx   = COORD_W'(vx);
        v.vy   = COORD_W'(vy);
        v.vz   = COORD_W'(vz);
        v.obj  = OBJ_W'(obj);
        v.vtx  = VTX_W'(vtx);
        v.last = last;
        return v;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(9))
            0, 1, 2, 3: return COORD_W'(int'($urandom_range(256)) - 128);
            4, 5, 6:    return COORD_W'(int'($urandom_range(8192)) - 4096);
            default:    return COORD_W'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    task automatic set_view(input logic signed [COORD_W-1:0] cx, input logic signed [COORD_W-1:0] cy,
                            input logic signed [COORD_W-1:0] cz, input logic signed [COORD_W-1:0] rx,
                            input logic signed [COORD_W-1:0] ry, input logic signed [COORD_W-1:0] rz,
                            input logic [DIST_W-1:0] thr);
        write_reg(CFG_CAMERA_X, CFG_DATA_W'(cx));
        write_reg(CFG_CAMERA_Y, CFG_DATA_W'(cy));
        write_reg(CFG_CAMERA_Z, CFG_DATA_W'(cz));
        write_reg(CFG_RAY_X, CFG_DATA_W'(rx));
        write_reg(CFG_RAY_Y, CFG_DATA_W'(ry));
        write_reg(CFG_RAY_Z, CFG_DATA_W'(rz));
        write_reg(CFG_THRESHOLD, thr);
        // unmapped index must leave every register alone
        write_reg(CFG_UNMAPPED, $urandom);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_vertex(input vertex_t v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        object_x     <= v.ox;
        object_y     <= v.oy;
        object_z     <= v.oz;
        vertex_x     <= v.vx;
        vertex_y     <= v.vy;
        vertex_z     <= v.vz;
        object_index <= v.obj;
        vertex_index <= v.vtx;
        frame_last   <= v.last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // block may still be working on a vertex that produces no result
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int                        frame_left;
        vertex_t                   v;
        vertex_t                   prev;
        logic signed [COORD_W-1:0] cx, cy, cz, rx, ry, rz;
        logic [DIST_W-1:0]         thr;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset view: camera at origin looking down z
        send_vertex(mk(0, 0, 0, 0, 0, 0, 1, 2, 0));
        send_vertex(mk(0, 0, 5, 0, 0, -3, 3, 4, 1));
        send_vertex(mk(32767, 32767, 32767, 32767, 32767, 32767, 255, 65535, 1));
        send_vertex(mk(-32768, -32768, -32768, 32767, 32767, 32767, 255, 65535, 1));
        send_vertex(mk(77, 0, 0, 0, 0, 0, 7, 9, 1));
        send_vertex(mk(0, 76, 0, 0, 0, 0, 8, 10, 1));
        send_vertex(mk(100, 0, 0, 0, 0, 0, 20, 0, 0));
        send_vertex(mk(50, 0, 0, 0, 0, 0, 21, 1, 0));
        send_vertex(mk(-50, 0, 0, 0, 0, 0, 22, 2, 0));
        send_vertex(mk(10, 0, 0, 0, 0, 0, 23, 3, 1));
        settle();

        set_view(32767, -32768, 32767, -16384, 0, 0, DIST_MAX);
        send_vertex(mk(-32768, 32767, -32768, -32768, 32767, -32768, 5, 6, 1));
        send_vertex(mk(0, 0, 0, 0, 0, 0, 9, 9, 1));
        settle();

        set_view(-32768, 32767, -32768, 16384, -16384, 16384, '0);
        send_vertex(mk(-32768, 32767, -32768, 0, 0, 0, 'h55, 'haaaa, 1));
        send_vertex(mk(0, 0, 0, 0, 0, 0, 'haa, 'h5555, 1));
        settle();

        set_view(0, 0, 0, 0, 0, RAY_Z_RESET, 5776);
        send_vertex(mk(76, 0, 0, 0, 0, 0, 1, 1, 1));
        send_vertex(mk(76, 1, 0, 0, 0, 0, 2, 2, 1));
        settle();

        prev = '0;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == SEGMENTS / 3)
            begin
                send_idle_pct = 88;
                recv_idle_pct = 20;
            end
            if (seg == 2 * SEGMENTS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            rx = '0;
            ry = '0;
            rz = '0;
            case ($urandom_range(3))
                0:
                begin
                    case ($urandom_range(2))
                        0: rx = COORD_W'($urandom_range(1) ? 16384 : -16384);
                        1: ry = COORD_W'($urandom_range(1) ? 16384 : -16384);
                        default: rz = COORD_W'($urandom_range(1) ? 16384 : -16384);
                    endcase
                end
                3:
                begin
                    rx = COORD_W'($urandom);
                    ry = COORD_W'($urandom);
                    rz = COORD_W'($urandom);
                end
                default:
                begin
                    rx = COORD_W'(int'($urandom_range(32768)) - 16384);
                    ry = COORD_W'(int'($urandom_range(32768)) - 16384);
                    rz = COORD_W'(int'($urandom_range(32768)) - 16384);
                end
            endcase
            if ($urandom_range(1))
            begin
                cx = COORD_W'(int'($urandom_range(512)) - 256);
                cy = COORD_W'(int'($urandom_range(512)) - 256);
                cz = COORD_W'(int'($urandom_range(512)) - 256);
            end
            else
            begin
                cx = COORD_W'($urandom);
                cy = COORD_W'($urandom);
                cz = COORD_W'($urandom);
            end
            case ($urandom_range(4))
                0:       thr = '0;
                1:       thr = DIST_MAX;
                2:       thr = $urandom;
                default: thr = $urandom_range(200000);
            endcase
            set_view(cx, cy, cz, rx, ry, rz, thr);

            frame_left = 0;
            for (int k = 0; k < SEGMENT_ITEMS; k++)
            begin
                if (frame_left == 0)
                    frame_left = ($urandom_range(7) == 0) ? $urandom_range(17, 60)
                                                          : $urandom_range(1, 16);
                // repeated position with new indices exercises ties
                if ($urandom_range(9) == 0)
                    v = prev;
                else
                begin
                    v.ox = rand_coord();
                    v.oy = rand_coord();
                    v.oz = rand_coord();
                    v.vx = rand_coord();
                    v.vy = rand_coord();
                    v.vz = rand_coord();
                end
                v.obj = OBJ_W'($urandom);
                v.vtx = VTX_W'($urandom);
                frame_left--;
                v.last = (frame_left == 0) || (k == SEGMENT_ITEMS - 1);
                send_vertex(v);
                prev = v;
            end
            settle();
        end

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
